FILE: src/allm_pkg.sv
// Shared types and constants for the array linked list manager.
package allm_pkg;

    // Widest slot pointer the block supports, none marker included (127 slots).
    localparam int ALLM_PTR_W = 7;

    typedef enum logic [2:0] {
        A_ADD_FIRST = 3'd0,
        A_ADD_AFTER = 3'd1,
        A_ADD_LAST  = 3'd2,
        A_DEL_FIRST = 3'd3,
        A_DEL_AFTER = 3'd4,
        A_DEL_LAST  = 3'd5,
        A_DEL_ALL   = 3'd6,
        A_READ_ALL  = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_BAD_POS = 3'd3,
        ST_NO_NEXT = 3'd4
    } t_status;

    // Table requests from the sequencer, one cycle each.
    typedef struct packed {
        logic [ALLM_PTR_W-1:0] rd_addr;   // slot read into the link and data registers
        logic                  occ_en;    // occupy: mark used, write link and data
        logic [ALLM_PTR_W-1:0] occ_addr;
        logic [ALLM_PTR_W-1:0] occ_link;
        logic                  lnk_en;    // rewrite one link
        logic [ALLM_PTR_W-1:0] lnk_addr;
        logic [ALLM_PTR_W-1:0] lnk_link;
        logic                  rel_en;    // release: mark free
        logic [ALLM_PTR_W-1:0] rel_addr;
        logic                  clr_all;   // free every slot
    } t_tbl_req;

    typedef struct packed {
        logic                  free_ok;
        logic [ALLM_PTR_W-1:0] free_slot;
    } t_tbl_rsp;

endpackage

FILE: src/allm_table.sv
// Slot table: link and data memories, used marks and lowest free slot finder.
module allm_table
    import allm_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_tbl_req                      i_req,
    input  logic [DATA_WIDTH-1:0]         i_wr_data,
    output logic [$clog2(SLOTS+1)-1:0]    o_link_q,
    output logic [DATA_WIDTH-1:0]         o_data_q,
    output logic [SLOTS-1:0]              o_used,
    output t_tbl_rsp                      o_rsp
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS+1);

    logic [PW-1:0]         mem_link [SLOTS];
    logic [DATA_WIDTH-1:0] mem_data [SLOTS];

    logic [PW-1:0]         r_link_q;
    logic [DATA_WIDTH-1:0] r_data_q;
    logic [SLOTS-1:0]      r_used;
    logic [SW-1:0]         r_free;
    logic                  r_free_ok;

    logic                  lw_en;
    logic [SW-1:0]         lw_addr;
    logic [PW-1:0]         lw_val;
    logic [SW-1:0]         n_free;
    logic                  n_free_ok;

    // One link write port shared by occupy and relink.
    always_comb begin
        lw_en   = i_req.occ_en | i_req.lnk_en;
        lw_addr = i_req.occ_en ? SW'(i_req.occ_addr) : SW'(i_req.lnk_addr);
        lw_val  = i_req.occ_en ? PW'(i_req.occ_link) : PW'(i_req.lnk_link);
    end

    always_ff @(posedge i_clk) begin
        if (lw_en) begin
            mem_link[lw_addr] <= lw_val;
        end
        r_link_q <= mem_link[SW'(i_req.rd_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.occ_en) begin
            mem_data[SW'(i_req.occ_addr)] <= i_wr_data;
        end
        r_data_q <= mem_data[SW'(i_req.rd_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_req.clr_all) begin
            r_used <= '0;
        end else begin
            if (i_req.occ_en) begin
                r_used[SW'(i_req.occ_addr)] <= 1'b1;
            end
            if (i_req.rel_en) begin
                r_used[SW'(i_req.rel_addr)] <= 1'b0;
            end
        end
    end

    // Lowest free slot, registered from the used marks.
    always_comb begin
        n_free    = '0;
        n_free_ok = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                n_free    = SW'(i);
                n_free_ok = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free    <= '0;
            r_free_ok <= 1'b1;
        end else begin
            r_free    <= n_free;
            r_free_ok <= n_free_ok;
        end
    end

    assign o_link_q        = r_link_q;
    assign o_data_q        = r_data_q;
    assign o_used          = r_used;
    assign o_rsp.free_ok   = r_free_ok;
    assign o_rsp.free_slot = ALLM_PTR_W'(r_free);

endmodule

FILE: src/array_linked_list_manager_unit.sv
// Top level of the array linked list manager: sequencer, list registers and result register.
//
// Singly linked list held in a table of SLOTS slots. The input channel
// (i_in_valid / o_in_stall) takes one action beat: add first, add after a
// slot, add last, delete first, delete after a slot, delete last, delete all,
// read all. The output channel (o_out_valid / i_out_stall) returns result
// beats; every action gives one beat except read all on a non-empty list,
// which gives one beat per entry in list order, o_last_result marking the end.
// A new entry always takes the lowest free slot.
// The link memory read port is the one shared unit; the sequencer follows one
// link per cycle through it, read all only while its result is not stalled.
// Add first, delete first, delete all and errors finish in the start state;
// add after and delete after go on to the link or delete state; add last
// walks to the tail and then links; delete last walks to the tail in the
// delete state; read all loads one beat per entry in the read state.
// o_in_stall is high from accept until the last result beat is loaded.
// Reset (synchronous, active low) empties the list at once: used marks
// cleared, head set to the none marker, count zero; no clearing pass.
// A stalled result holds in the output register; the sequencer waits on it.
module array_linked_list_manager_unit
    import allm_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // action channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [3:0]  i_position_slot,
    input  logic [63:0] i_entry_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot_index,
    output logic [63:0] o_read_data,
    output logic [4:0]  o_entry_count,
    output logic        o_last_result
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = $clog2(SLOTS+1);
    localparam int CW = PW + 4;
    localparam logic [PW-1:0] NONE = PW'(SLOTS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,   // first look at head or position slot
        S_WALK  = 6'b000100,   // add last: walk to the tail
        S_LINK  = 6'b001000,   // hook the new slot behind its predecessor
        S_DEL   = 6'b010000,   // unlink a victim; delete last walks here
        S_READ  = 6'b100000    // read all: one beat per entry
    } t_state;

    t_state                r_state, n_state;
    t_action               r_act;
    logic [DATA_WIDTH-1:0] r_din;
    logic [PW-1:0]         r_cur, n_cur;
    logic [PW-1:0]         r_prev, n_prev;
    logic [PW-1:0]         r_steps, n_steps;
    logic [SW-1:0]         r_new, n_new;
    logic [PW-1:0]         r_head, n_head;
    logic [PW-1:0]         r_count, n_count;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [3:0]            r_out_slot;
    logic [63:0]           r_out_data;
    logic [4:0]            r_out_count;
    logic                  r_out_last;

    t_tbl_req              tbl_req;
    t_tbl_rsp              tbl_rsp;
    logic [PW-1:0]         link_q;
    logic [DATA_WIDTH-1:0] data_q;
    logic [SLOTS-1:0]      used;

    logic                  accept;
    logic                  can_emit;
    logic                  cur_ok;
    logic                  nx_ok;
    logic                  full;
    logic                  pos_ok;

    logic                  emit;
    t_status               e_status;
    logic [SW-1:0]         e_slot;
    logic [DATA_WIDTH-1:0] e_data;
    logic [PW-1:0]         e_count;
    logic                  e_last;

    function automatic logic slot_valid(input logic [PW-1:0] x, input logic [SLOTS-1:0] u);
        logic ok;
        ok = (x < NONE) && u[SW'(x)];
        return ok;
    endfunction

    allm_table #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .i_wr_data (r_din),
        .o_link_q  (link_q),
        .o_data_q  (data_q),
        .o_used    (used),
        .o_rsp     (tbl_rsp)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign can_emit = !r_out_valid || !i_out_stall;
    // link_q and data_q hold the entries of slot r_cur, read at the edge that loaded r_cur
    assign cur_ok   = slot_valid(r_cur, used);
    assign nx_ok    = slot_valid(link_q, used);
    assign full     = (r_count >= NONE) || !tbl_rsp.free_ok;
    assign pos_ok   = CW'(i_position_slot) < CW'(SLOTS);

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_steps  = r_steps;
        n_new    = r_new;
        n_head   = r_head;
        n_count  = r_count;
        emit     = 1'b0;
        e_status = ST_OK;
        e_slot   = '0;
        e_data   = '0;
        e_count  = r_count;
        e_last   = 1'b1;
        tbl_req  = '0;

        case (r_state)
            S_IDLE: begin
                n_cur = r_head;
                if (accept) begin
                    if (t_action'(i_action) == A_ADD_AFTER ||
                        t_action'(i_action) == A_DEL_AFTER) begin
                        n_cur = pos_ok ? PW'(i_position_slot) : NONE;
                    end
                    n_steps = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (can_emit) begin
                    case (r_act)
                        A_ADD_FIRST, A_ADD_LAST: begin
                            if (full) begin
                                emit     = 1'b1;
                                e_status = ST_FULL;
                                n_state  = S_IDLE;
                            end else if (r_act == A_ADD_FIRST || !cur_ok) begin
                                // new head, old head behind it
                                tbl_req.occ_en   = 1'b1;
                                tbl_req.occ_addr = tbl_rsp.free_slot;
                                tbl_req.occ_link = ALLM_PTR_W'(r_head);
                                n_head   = PW'(tbl_rsp.free_slot);
                                n_count  = r_count + PW'(1);
                                emit     = 1'b1;
                                e_slot   = SW'(tbl_rsp.free_slot);
                                e_count  = n_count;
                                n_state  = S_IDLE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        A_ADD_AFTER: begin
                            if (full || !cur_ok) begin
                                emit     = 1'b1;
                                e_status = full ? ST_FULL : ST_BAD_POS;
                                n_state  = S_IDLE;
                            end else begin
                                tbl_req.occ_en   = 1'b1;
                                tbl_req.occ_addr = tbl_rsp.free_slot;
                                tbl_req.occ_link = ALLM_PTR_W'(link_q);
                                n_new   = SW'(tbl_rsp.free_slot);
                                n_count = r_count + PW'(1);
                                n_state = S_LINK;
                            end
                        end
                        A_DEL_FIRST, A_DEL_LAST: begin
                            if (!cur_ok) begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                                n_state  = S_IDLE;
                            end else if (r_act == A_DEL_FIRST || !nx_ok) begin
                                // drop the head
                                n_head  = nx_ok ? link_q : NONE;
                                tbl_req.rel_en   = 1'b1;
                                tbl_req.rel_addr = ALLM_PTR_W'(r_cur);
                                n_count = (r_count != '0) ? r_count - PW'(1) : r_count;
                                emit    = 1'b1;
                                e_slot  = SW'(r_cur);
                                e_data  = data_q;
                                e_count = n_count;
                                n_state = S_IDLE;
                            end else begin
                                n_prev  = r_cur;
                                n_cur   = link_q;
                                n_state = S_DEL;
                            end
                        end
                        A_DEL_AFTER: begin
                            if (!cur_ok || !nx_ok) begin
                                emit     = 1'b1;
                                e_status = !cur_ok ? ST_BAD_POS : ST_NO_NEXT;
                                n_state  = S_IDLE;
                            end else begin
                                n_prev  = r_cur;
                                n_cur   = link_q;
                                n_state = S_DEL;
                            end
                        end
                        A_DEL_ALL: begin
                            tbl_req.clr_all = 1'b1;
                            n_head  = NONE;
                            n_count = '0;
                            emit    = 1'b1;
                            e_count = '0;
                            n_state = S_IDLE;
                        end
                        A_READ_ALL: begin
                            if (!cur_ok) begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                                n_state  = S_IDLE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (!nx_ok || r_steps == NONE) begin
                    // r_cur is the tail: occupy the free slot behind it
                    tbl_req.occ_en   = 1'b1;
                    tbl_req.occ_addr = tbl_rsp.free_slot;
                    tbl_req.occ_link = ALLM_PTR_W'(link_q);
                    n_new   = SW'(tbl_rsp.free_slot);
                    n_count = r_count + PW'(1);
                    n_state = S_LINK;
                end else begin
                    n_cur   = link_q;
                    n_steps = r_steps + PW'(1);
                end
            end
            S_LINK: begin
                if (can_emit) begin
                    tbl_req.lnk_en   = 1'b1;
                    tbl_req.lnk_addr = ALLM_PTR_W'(r_cur);
                    tbl_req.lnk_link = ALLM_PTR_W'(r_new);
                    emit    = 1'b1;
                    e_slot  = r_new;
                    n_state = S_IDLE;
                end
            end
            S_DEL: begin
                if (r_act == A_DEL_LAST && nx_ok && r_steps != NONE) begin
                    // victim still has a successor: advance
                    n_prev  = r_cur;
                    n_cur   = link_q;
                    n_steps = r_steps + PW'(1);
                end else if (can_emit) begin
                    tbl_req.lnk_en   = 1'b1;
                    tbl_req.lnk_addr = ALLM_PTR_W'(r_prev);
                    tbl_req.lnk_link = ALLM_PTR_W'(nx_ok ? link_q : NONE);
                    tbl_req.rel_en   = 1'b1;
                    tbl_req.rel_addr = ALLM_PTR_W'(r_cur);
                    n_count = (r_count != '0) ? r_count - PW'(1) : r_count;
                    emit    = 1'b1;
                    e_slot  = SW'(r_cur);
                    e_data  = data_q;
                    e_count = n_count;
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    e_slot  = SW'(r_cur);
                    e_data  = data_q;
                    e_last  = !nx_ok || (r_steps == NONE - PW'(1));
                    n_cur   = link_q;
                    n_steps = r_steps + PW'(1);
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        tbl_req.rd_addr = ALLM_PTR_W'(n_cur);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        r_new   <= n_new;
        if (accept) begin
            r_act <= t_action'(i_action);
            r_din <= i_entry_data[DATA_WIDTH-1:0];
        end
        if (emit) begin
            r_out_status <= e_status;
            r_out_slot   <= 4'(e_slot);
            r_out_data   <= 64'(e_data);
            r_out_count  <= 5'(e_count);
            r_out_last   <= e_last;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot_index  = r_out_slot;
    assign o_read_data   = r_out_data;
    assign o_entry_count = r_out_count;
    assign o_last_result = r_out_last;

endmodule
